// ----- src/assert_macros.svh -----
// Assertion macros for the RTL files; srecord_loader.sv is the one that includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property checked on every rising clock edge outside reset.
`define SREC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define SREC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SREC_ASSERT(lbl, clk, rst_n, prop, msg)
`define SREC_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ----- src/srec_pkg.sv -----
`default_nettype none

package srec_pkg;

    // Field widths of the two channels and of the APB port.
    localparam int CHAR_W = 8;
    localparam int KIND_W = 2;
    localparam int OUT_ADDR_W = 32;
    localparam int DATA_W = 16;
    localparam int CFG_W = 32;
    localparam int PADDR_W = 2;

    // Default sizes handed to the top level.
    localparam int MAX_LINE_CHARS_DEF = 80;
    localparam int ADDR_WIDTH_DEF = 32;

    // Reset value of the code base register.
    localparam logic [CFG_W-1:0] CODE_BASE_RESET = 32'h8000_0000;

    // Character positions within a line.
    localparam int ADDR_FIELD_START = 4;
    localparam int PAYLOAD_START = 12;

    // ASCII codes.
    localparam logic [CHAR_W-1:0] CHAR_S = 8'h53;
    localparam logic [CHAR_W-1:0] CHAR_0 = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_9 = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_F = 8'h46;

    // Record types of interest.
    localparam logic [3:0] REC_DATA4 = 4'd3;
    localparam logic [3:0] REC_DATA4_END = 4'd7;

    // Register index of code_base.
    localparam int REG_CODE_BASE = 0;

    // Input commands.
    typedef enum logic {
        CMD_CHAR = 1'b0,
        CMD_EOL  = 1'b1
    } t_cmd;

    // Result kinds.
    typedef enum logic [KIND_W-1:0] {
        KIND_CODE  = 2'd0,
        KIND_DATA  = 2'd1,
        KIND_START = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind                 kind;
        logic [OUT_ADDR_W-1:0] address;
        logic [DATA_W-1:0]     data;
    } t_result;

    // Hex digit value; anything other than 0-9 or A-F counts as zero.
    function automatic logic [3:0] hex_value(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] d;
        d = '0;
        if (c >= CHAR_0 && c <= CHAR_9) begin
            d = c - CHAR_0;
        end else if (c >= CHAR_A && c <= CHAR_F) begin
            d = c - CHAR_A + 8'd10;
        end
        return d[3:0];
    endfunction

endpackage

`default_nettype wire

// ----- src/srec_in_if.sv -----
`default_nettype none

// Character channel: one character or an end-of-line event per transfer.
interface srec_in_if;
    logic                          valid;
    logic                          ready;
    logic                          cmd;
    logic [srec_pkg::CHAR_W-1:0]   character;

    modport source (output valid, cmd, character, input ready);
    modport sink (input valid, cmd, character, output ready);
endinterface

`default_nettype wire

// ----- src/srec_out_if.sv -----
`default_nettype none

// Result channel: a code word write, a data byte write or a start request.
interface srec_out_if;
    logic                              valid;
    logic                              ready;
    logic [srec_pkg::KIND_W-1:0]       kind;
    logic [srec_pkg::OUT_ADDR_W-1:0]   address;
    logic [srec_pkg::DATA_W-1:0]       data;

    modport source (output valid, kind, address, data, input ready);
    modport sink (input valid, kind, address, data, output ready);
endinterface

`default_nettype wire

// ----- src/srecord_loader.sv -----
`default_nettype none
`include "assert_macros.svh"

// Channel   Direction  Handshake         Payload
// i_in      sink       valid / ready     cmd, character
// o_out     source     valid / ready     kind, address, data
// APB       slave      psel / penable    code_base at every byte address (paddr is not decoded)
//
// One transfer is taken per cycle while i_in.ready is high; each character
// updates the line state and its result, if any, is registered in the output
// register, or in the skid stage while o_out is stalled. The throughput of one
// item per cycle is set by the output register and its skid stage: i_in.ready
// falls only while the skid stage holds a result. Synchronous active-low reset
// clears all line state and sets code_base to 0x80000000.

module srecord_loader #(
    parameter int MAX_LINE_CHARS = srec_pkg::MAX_LINE_CHARS_DEF,
    parameter int ADDR_WIDTH     = srec_pkg::ADDR_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    srec_in_if.sink                            i_in,
    srec_out_if.source                         o_out,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [srec_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [srec_pkg::CFG_W-1:0]    pwdata,
    output logic [srec_pkg::CFG_W-1:0]         prdata,
    output logic                               pready
);

    localparam int POS_W = $clog2(MAX_LINE_CHARS + 1);
    localparam int AW = ADDR_WIDTH;
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LINE_CHARS);
    localparam logic [POS_W-1:0] POS_TYPE = POS_W'(1);
    localparam logic [POS_W-1:0] POS_ADDR = POS_W'(srec_pkg::ADDR_FIELD_START);
    localparam logic [POS_W-1:0] POS_PAY = POS_W'(srec_pkg::PAYLOAD_START);
    localparam logic [POS_W-1:0] POS_ADDR_LAST = POS_W'(srec_pkg::PAYLOAD_START - 1);

    // Configuration register.
    logic [srec_pkg::CFG_W-1:0] r_code_base;

    // Line state.
    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_accepted, n_accepted;
    logic [3:0]       r_rec_kind, n_rec_kind;
    logic [AW-1:0]    r_load, n_load;
    logic [3:0]       r_high, n_high;
    logic [7:0]       r_held, n_held;
    logic             r_held_valid, n_held_valid;
    logic [7:0]       r_low, n_low;
    logic             r_low_valid, n_low_valid;
    logic [5:0]       r_bytes_done, n_bytes_done;
    logic             r_to_code, n_to_code;

    // Output register and skid stage.
    srec_pkg::t_result r_out, n_out;
    logic              r_out_valid, n_out_valid;
    srec_pkg::t_result r_skid, n_skid;
    logic              r_skid_valid, n_skid_valid;

    // Result of the item in this cycle.
    srec_pkg::t_result res;
    logic              res_valid;

    logic          in_fire;
    logic          out_fire;
    logic          cfg_write;
    logic [3:0]    digit;
    logic [7:0]    byte_val;
    logic [AW-1:0] base_m;
    logic [AW-1:0] diff;
    logic [AW-1:0] word_addr;
    logic [AW-1:0] data_addr;
    logic [AW-1:0] shifted_load;
    logic [srec_pkg::OUT_ADDR_W-1:0] word_addr_ext;
    logic [srec_pkg::OUT_ADDR_W-1:0] data_addr_ext;

    assign i_in.ready = !r_skid_valid;
    assign in_fire    = i_in.valid && i_in.ready;
    assign out_fire   = r_out_valid && o_out.ready;

    assign o_out.valid   = r_out_valid;
    assign o_out.kind    = r_out.kind;
    assign o_out.address = r_out.address;
    assign o_out.data    = r_out.data;

    // APB access: single register, no wait states.
    assign pready    = 1'b1;
    assign prdata    = r_code_base;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_base <= srec_pkg::CODE_BASE_RESET;
        end else if (cfg_write && (paddr >> 2) == srec_pkg::PADDR_W'(srec_pkg::REG_CODE_BASE)) begin
            r_code_base <= pwdata;
        end
    end

    // Address arithmetic for the payload bytes.
    assign digit        = srec_pkg::hex_value(i_in.character);
    assign byte_val     = {r_high, digit};
    assign base_m       = r_code_base[AW-1:0];
    assign diff         = r_load - base_m;
    assign word_addr    = (diff >> 1) + AW'(r_bytes_done[5:1]);
    assign data_addr    = r_load + AW'(r_bytes_done);
    assign shifted_load = {r_load[AW-5:0], digit};

    always_comb begin
        word_addr_ext = '0;
        word_addr_ext[AW-1:0] = word_addr;
        data_addr_ext = '0;
        data_addr_ext[AW-1:0] = data_addr;
    end

    // Line parser: next line state and the result of the accepted item.
    always_comb begin
        n_pos        = r_pos;
        n_accepted   = r_accepted;
        n_rec_kind   = r_rec_kind;
        n_load       = r_load;
        n_high       = r_high;
        n_held       = r_held;
        n_held_valid = r_held_valid;
        n_low        = r_low;
        n_low_valid  = r_low_valid;
        n_bytes_done = r_bytes_done;
        n_to_code    = r_to_code;
        res_valid    = 1'b0;
        res.kind     = srec_pkg::KIND_START;
        res.address  = '0;
        res.data     = '0;

        if (in_fire) begin
            if (i_in.cmd == srec_pkg::CMD_EOL) begin
                // End of line: a terminating S7 record asks for a start.
                res_valid    = r_accepted && r_rec_kind == srec_pkg::REC_DATA4_END;
                n_pos        = '0;
                n_accepted   = 1'b0;
                n_rec_kind   = '0;
                n_load       = '0;
                n_high       = '0;
                n_held       = '0;
                n_held_valid = 1'b0;
                n_low        = '0;
                n_low_valid  = 1'b0;
                n_bytes_done = '0;
                n_to_code    = 1'b0;
            end else if (r_pos < POS_MAX) begin
                n_pos = r_pos + POS_W'(1);
                if (r_pos == '0) begin
                    n_accepted = i_in.character == srec_pkg::CHAR_S;
                end else if (!r_accepted) begin
                    n_accepted = r_accepted;
                end else if (r_pos == POS_TYPE) begin
                    n_rec_kind = digit;
                end else if (r_rec_kind != srec_pkg::REC_DATA4 || r_pos < POS_ADDR) begin
                    n_rec_kind = r_rec_kind;
                end else if (r_pos < POS_PAY) begin
                    // Address digits, most significant first.
                    n_load = shifted_load;
                    if (r_pos == POS_ADDR_LAST) begin
                        n_to_code = shifted_load >= base_m;
                    end
                end else if (!r_pos[0]) begin
                    n_high = digit;
                end else begin
                    // A byte is complete; the byte held back is written now, or kept as a code low byte.
                    n_held       = byte_val;
                    n_held_valid = 1'b1;
                    if (r_held_valid) begin
                        n_bytes_done = r_bytes_done + 6'd1;
                        if (r_to_code) begin
                            if (!r_low_valid) begin
                                n_low       = r_held;
                                n_low_valid = 1'b1;
                            end else begin
                                res_valid   = 1'b1;
                                res.kind    = srec_pkg::KIND_CODE;
                                res.address = word_addr_ext;
                                res.data    = {r_held, r_low};
                                n_low_valid = 1'b0;
                            end
                        end else begin
                            res_valid   = 1'b1;
                            res.kind    = srec_pkg::KIND_DATA;
                            res.address = data_addr_ext;
                            res.data    = {8'h00, r_held};
                        end
                    end
                end
            end
        end
    end

    // Output register with a skid stage behind it.
    always_comb begin
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        n_skid       = r_skid;
        n_skid_valid = r_skid_valid;
        if (r_skid_valid) begin
            if (out_fire) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (res_valid) begin
            if (!r_out_valid || out_fire) begin
                n_out       = res;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = res;
                n_skid_valid = 1'b1;
            end
        end else if (out_fire) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_accepted   <= 1'b0;
            r_rec_kind   <= '0;
            r_load       <= '0;
            r_high       <= '0;
            r_held       <= '0;
            r_held_valid <= 1'b0;
            r_low        <= '0;
            r_low_valid  <= 1'b0;
            r_bytes_done <= '0;
            r_to_code    <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_pos        <= n_pos;
            r_accepted   <= n_accepted;
            r_rec_kind   <= n_rec_kind;
            r_load       <= n_load;
            r_high       <= n_high;
            r_held       <= n_held;
            r_held_valid <= n_held_valid;
            r_low        <= n_low;
            r_low_valid  <= n_low_valid;
            r_bytes_done <= n_bytes_done;
            r_to_code    <= n_to_code;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // Result payloads carry no reset.
    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    // Checks on the skid stage and the line state.
    `SREC_ASSERT(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid |-> r_out_valid, "skid stage full while output register empty")
    `SREC_ASSERT(a_pos_bounded, i_clk, i_rst_n, r_pos <= POS_MAX, "character position past line limit")
    `SREC_ASSERT(a_eol_clears, i_clk, i_rst_n, (in_fire && i_in.cmd == srec_pkg::CMD_EOL) |=> (r_pos == '0 && !r_held_valid && !r_low_valid), "line state not cleared at end of line")
    `SREC_ASSERT(a_low_needs_code, i_clk, i_rst_n, r_low_valid |-> r_to_code, "code byte pending on a data line")

endmodule

`default_nettype wire
